// ===== design/wps_pkg.sv =====
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types, constants and symbol coding for the wildcard pattern search.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int PATTERN_LEN = 16;
  localparam int TEXT_LIMIT  = 65536;
  localparam int MATCH_LIMIT = 1024;

  localparam int SYM_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int POS_W    = 16;
  localparam int COUNT_W  = 11;

  localparam logic [SYM_W-1:0]  WILDCARD = 5'h1f;
  localparam logic [BYTE_W-1:0] QMARK    = 8'h3f;
  localparam logic [BYTE_W-1:0] BACKTICK = 8'h60;

  typedef enum logic [MODE_W-1:0] {
    MODE_PATTERN = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_EOT     = 2'd2
  } mode_e;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Byte to 5-bit symbol; '?' becomes the wildcard.
  function automatic logic [SYM_W-1:0] encode(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] diff;
    diff = b - BACKTICK;
    if (b == QMARK) begin
      return WILDCARD;
    end
    return diff[SYM_W-1:0];
  endfunction

endpackage

// ===== design/wps_match.sv =====
// ----------------------------------------------------------------------------
// wps_match
// Parallel compare of the window against the pattern, wildcards match all.
// ----------------------------------------------------------------------------
module wps_match
  import wps_pkg::*;
#(
  parameter int PatternLen = PATTERN_LEN
) (
  input  logic [PatternLen-1:0][SYM_W-1:0] pattern_i,
  input  logic [PatternLen-1:0][SYM_W-1:0] window_i,
  output logic                             hit_o
);

  logic [PatternLen-1:0] lane_ok;

  always_comb begin
    for (int i = 0; i < PatternLen; i++) begin
      lane_ok[i] = (pattern_i[i] == WILDCARD) || (pattern_i[i] == window_i[i]);
    end
  end

  assign hit_o = &lane_ok;

endmodule

// ===== design/wildcard_pattern_search.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_search
// Flow: an item is held in the input register, then its result lands in the
// result register. Throughput: one pattern or text item per cycle while the
// result side does not stall, set by the single-pass window compare; an
// end-of-text item is held for its padding flush (one padding shift per
// cycle, then the count). Reset: pattern and window all wildcard,
// counters and flags cleared, both registers empty.
// ----------------------------------------------------------------------------
module wildcard_pattern_search
  import wps_pkg::*;
#(
  parameter int PatternLen = PATTERN_LEN,
  parameter int TextLimit  = TEXT_LIMIT,
  parameter int MatchLimit = MATCH_LIMIT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [INDEX_W-1:0] pattern_index_i,
  input  logic [BYTE_W-1:0]  symbol_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [POS_W-1:0]   position_o,
  output logic [COUNT_W-1:0] match_count_o,
  output logic               truncated_o,
  output logic               last_o
);

  localparam int LenW  = $clog2(TextLimit + 1);
  localparam int CntW  = $clog2(MatchLimit + 1);
  localparam int SumW  = LenW + 7;
  localparam int StepW = (PatternLen > 1) ? $clog2(PatternLen) : 1;

  // Input register: holds the item under work.
  logic               it_valid_q;
  logic [MODE_W-1:0]  it_mode_q;
  logic [INDEX_W-1:0] it_idx_q;
  logic [BYTE_W-1:0]  it_sym_q;

  // Search state.
  logic [PatternLen-1:0][SYM_W-1:0] pat_q, pat_d;
  logic [PatternLen-1:0][SYM_W-1:0] win_q, win_d, win_sh;
  logic [LenW-1:0]                  len_q, len_d;
  logic [CntW-1:0]                  found_q, found_d;
  logic                             ovf_q, ovf_d;
  logic [StepW-1:0]                 step_q, step_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic               res_kind_q, res_kind_d;
  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  logic [COUNT_W-1:0] res_cnt_q, res_cnt_d;
  logic               res_trunc_q, res_trunc_d;
  logic               res_last_q, res_last_d;

  logic             out_free, fire, it_done, step_last, hit, report, in_accept;
  logic [SYM_W-1:0] shift_sym;
  logic [SumW-1:0]  offset, sum;

  // The result register frees up in the same cycle its transfer completes.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = it_valid_q && out_free;
  assign step_last = (step_q == StepW'(PatternLen - 1));
  // An end-of-text item stays until its count result is loaded into the result register.
  assign it_done    = fire && ((it_mode_q != MODE_EOT) || step_last);
  assign in_stall_o = it_valid_q && !it_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Window after one shift: a text symbol, or padding during the flush.
  assign shift_sym = (it_mode_q == MODE_TEXT) ? encode(it_sym_q) : WILDCARD;

  always_comb begin
    for (int i = 0; i < PatternLen; i++) begin
      win_sh[i] = (i < PatternLen - 1) ? win_q[(i + 1) % PatternLen] : shift_sym;
    end
  end

  wps_match #(
    .PatternLen(PatternLen)
  ) u_match (
    .pattern_i(pat_q),
    .window_i (win_sh),
    .hit_o    (hit)
  );

  // Symbols shifted so far after this step; the window start is that minus
  // the pattern length, and it lies inside the text whenever it is not
  // negative.
  assign offset = (it_mode_q == MODE_TEXT) ? SumW'(1) : (SumW'(step_q) + SumW'(1));
  assign sum    = SumW'(len_q) + offset;
  assign report = hit && (sum >= SumW'(PatternLen)) && (found_q < CntW'(MatchLimit));

  always_comb begin
    pat_d       = pat_q;
    win_d       = win_q;
    len_d       = len_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_kind_d  = res_kind_q;
    res_pos_d   = res_pos_q;
    res_cnt_d   = res_cnt_q;
    res_trunc_d = res_trunc_q;
    res_last_d  = res_last_q;

    if (fire) begin
      unique case (it_mode_q)
        MODE_PATTERN: begin
          // Positions past the pattern length are left alone.
          for (int i = 0; i < PatternLen; i++) begin
            if (int'(it_idx_q) == i) begin
              pat_d[i] = encode(it_sym_q);
            end
          end
        end
        MODE_TEXT: begin
          if (len_q >= LenW'(TextLimit)) begin
            ovf_d = 1'b1;
          end else begin
            win_d = win_sh;
            len_d = len_q + LenW'(1);
            if (report) begin
              found_d     = found_q + CntW'(1);
              out_valid_d = 1'b1;
              res_kind_d  = KIND_MATCH;
              res_pos_d   = POS_W'(sum - SumW'(PatternLen));
              res_cnt_d   = '0;
              res_trunc_d = 1'b0;
              res_last_d  = 1'b1;
            end
          end
        end
        MODE_EOT: begin
          if (!step_last) begin
            // Flush one padding symbol.
            win_d  = win_sh;
            step_d = step_q + StepW'(1);
            if (report) begin
              found_d     = found_q + CntW'(1);
              out_valid_d = 1'b1;
              res_kind_d  = KIND_MATCH;
              res_pos_d   = POS_W'(sum - SumW'(PatternLen));
              res_cnt_d   = '0;
              res_trunc_d = 1'b0;
              res_last_d  = 1'b0;
            end
          end else begin
            // Send the count and drop the per-text state; keep the pattern.
            out_valid_d = 1'b1;
            res_kind_d  = KIND_COUNT;
            res_pos_d   = '0;
            res_cnt_d   = COUNT_W'(found_q);
            res_trunc_d = ovf_q;
            res_last_d  = 1'b1;
            win_d       = {PatternLen{WILDCARD}};
            len_d       = '0;
            found_d     = '0;
            ovf_d       = 1'b0;
            step_d      = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_valid_q  <= 1'b0;
      pat_q       <= {PatternLen{WILDCARD}};
      win_q       <= {PatternLen{WILDCARD}};
      len_q       <= '0;
      found_q     <= '0;
      ovf_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        it_valid_q <= 1'b1;
      end else if (it_done) begin
        it_valid_q <= 1'b0;
      end
      pat_q       <= pat_d;
      win_q       <= win_d;
      len_q       <= len_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      it_mode_q <= mode_i;
      it_idx_q  <= pattern_index_i;
      it_sym_q  <= symbol_i;
    end
    res_kind_q  <= res_kind_d;
    res_pos_q   <= res_pos_d;
    res_cnt_q   <= res_cnt_d;
    res_trunc_q <= res_trunc_d;
    res_last_q  <= res_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = res_kind_q;
  assign position_o    = res_pos_q;
  assign match_count_o = res_cnt_q;
  assign truncated_o   = res_trunc_q;
  assign last_o        = res_last_q;

  // Match counter saturates at the limit.
  a_found_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= CntW'(MatchLimit))
    else $error("match counter past limit");

  // Text length never runs past the limit.
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(TextLimit))
    else $error("text length past limit");

  // Flush steps only run while an end-of-text item is held.
  a_step_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> (it_valid_q && (it_mode_q == MODE_EOT)))
    else $error("flush step without end-of-text item");

  // A count result always closes the run.
  a_count_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_kind_q == KIND_COUNT)) |-> res_last_q)
    else $error("count result without last");

  // Ending a run clears the per-text state.
  a_eot_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (it_mode_q == MODE_EOT) && step_last) |=> ((len_q == '0) && (found_q == '0)))
    else $error("per-text state not cleared");

endmodule

// ===== tb/wps_checker.sv =====
// ----------------------------------------------------------------------------
// wps_checker
// Watches both channels of the wildcard pattern search, keeps its own copy of
// pattern, window and counters, and checks every result transfer against the
// oldest predicted one.
// ----------------------------------------------------------------------------
module wps_checker
  import wps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [INDEX_W-1:0] pattern_index_i,
  input  logic [BYTE_W-1:0]  symbol_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               kind_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [COUNT_W-1:0] match_count_i,
  input  logic               truncated_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 predicted_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] match_count;
    logic               truncated;
    logic               last;
  } search_result_t;

  logic [SYM_W-1:0] pattern_sym [PATTERN_LEN];
  logic [SYM_W-1:0] window_sym  [PATTERN_LEN];
  int unsigned      text_len  = 0;
  int unsigned      hits      = 0;
  bit               overflow  = 1'b0;
  search_result_t   expected_results [$];
  int               fails     = 0;
  int               checked   = 0;

  // 0x60 is a multiple of 32, so the offset vanishes from the low five bits;
  // '?' (0x3f) falls on the wildcard code by itself.
  function automatic logic [SYM_W-1:0] sym_code(input logic [BYTE_W-1:0] b);
    return b[SYM_W-1:0];
  endfunction

  function automatic bit window_hit();
    for (int i = 0; i < PATTERN_LEN; i++) begin
      if (pattern_sym[i] != WILDCARD && window_sym[i] != pattern_sym[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic shift_window(input logic [SYM_W-1:0] s);
    for (int i = 0; i < PATTERN_LEN - 1; i++) begin
      window_sym[i] = window_sym[i + 1];
    end
    window_sym[PATTERN_LEN - 1] = s;
  endtask

  task automatic clear_text();
    for (int i = 0; i < PATTERN_LEN; i++) begin
      window_sym[i] = WILDCARD;
    end
    text_len = 0;
    hits     = 0;
    overflow = 1'b0;
  endtask

  // shifted counts every symbol pushed so far, padding included
  task automatic check_start(input int unsigned shifted, input logic last);
    int unsigned start;
    if (shifted < PATTERN_LEN) begin
      return;
    end
    start = shifted - PATTERN_LEN;
    if (start >= text_len || hits >= MATCH_LIMIT || !window_hit()) begin
      return;
    end
    hits++;
    expected_results.push_back('{KIND_MATCH, POS_W'(start), COUNT_W'(0), 1'b0, last});
  endtask

  task automatic predict_transfer(input logic [MODE_W-1:0]  mode,
                                  input logic [INDEX_W-1:0] idx,
                                  input logic [BYTE_W-1:0]  b);
    case (mode)
      MODE_PATTERN: begin
        pattern_sym[idx] = sym_code(b);
      end
      MODE_TEXT: begin
        if (text_len >= TEXT_LIMIT) begin
          overflow = 1'b1;
        end else begin
          shift_window(sym_code(b));
          text_len++;
          check_start(text_len, 1'b1);
        end
      end
      MODE_EOT: begin
        // flush padding so windows running past the end still get a look
        for (int k = 1; k < PATTERN_LEN; k++) begin
          shift_window(WILDCARD);
          check_start(text_len + k, 1'b0);
        end
        expected_results.push_back('{KIND_COUNT, POS_W'(0), COUNT_W'(hits), overflow, 1'b1});
        clear_text();
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_result();
    search_result_t got;
    search_result_t want;
    got = '{kind_i, position_i, match_count_i, truncated_i, last_i};
    if (expected_results.size() == 0) begin
      fails++;
      if (fails <= MAX_REPORTS) begin
        $display("[%0t] unexpected result: kind %0d position %0d count %0d", $realtime,
                 got.kind, got.position, got.match_count,
                 " truncated %0d last %0d", got.truncated, got.last);
      end
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (got.kind !== want.kind || got.position !== want.position ||
        got.match_count !== want.match_count || got.truncated !== want.truncated ||
        got.last !== want.last) begin
      fails++;
      if (fails <= MAX_REPORTS) begin
        $display("[%0t] result %0d differs:", $realtime, checked);
        $display("  expected kind %0d position %0d count %0d truncated %0d last %0d",
                 want.kind, want.position, want.match_count, want.truncated, want.last);
        $display("  actual   kind %0d position %0d count %0d truncated %0d last %0d",
                 got.kind, got.position, got.match_count, got.truncated, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PATTERN_LEN; i++) begin
        pattern_sym[i] = WILDCARD;
      end
      clear_text();
      expected_results.delete();
    end else begin
      // results first: nothing accepted at this edge can already be out
      if (out_valid_i && !out_stall_i) begin
        compare_result();
      end
      if (in_valid_i && !in_stall_i) begin
        predict_transfer(mode_i, pattern_index_i, symbol_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
    predicted_o  <= checked + expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the wildcard pattern search with a short directed sequence, random
// pattern and text runs, and one long hold on the result side while text
// keeps arriving. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import wps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 55;
  localparam int HOLD_CYCLES   = 120;
  localparam int HOLD_TEXTS    = 20;
  // about 110 transfers and a few hundred results, each waiting out random
  // gaps or stalls, plus one long hold: well within the limit
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 2 * PATTERN_LEN + 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] pattern_index;
  logic [BYTE_W-1:0]  symbol;
  logic               out_valid;
  logic               out_stall;
  logic               kind;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] match_count;
  logic               truncated;
  logic               last;

  int fail_count;
  int pending;
  int checked;
  int predicted;

  // knobs shared between the sender and the result-side stall process
  int idle_pct  = 0;
  int stall_pct = 0;
  int stray_pct = 0;
  bit hold_req  = 1'b0;

  int items_sent  = 0;
  int texts_sent  = 0;
  int cycle_count = 0;

  // bytes last written to each pattern position, used to build matching text
  logic [BYTE_W-1:0] pattern_bytes [PATTERN_LEN];

  always #4 clk = ~clk;

  wildcard_pattern_search DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .pattern_index_i (pattern_index),
    .symbol_i        (symbol),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .position_o      (position),
    .match_count_o   (match_count),
    .truncated_o     (truncated),
    .last_o          (last)
  );

  wps_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .mode_i          (mode),
    .pattern_index_i (pattern_index),
    .symbol_i        (symbol),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .position_i      (position),
    .match_count_i   (match_count),
    .truncated_i     (truncated),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .predicted_o     (predicted)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Text leans on a tiny alphabet so that concrete pattern symbols still hit.
  function automatic logic [BYTE_W-1:0] text_byte();
    if ($urandom_range(0, 99) < 85) begin
      return BYTE_W'("a") + BYTE_W'($urandom_range(0, 2));
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Offer one item, idling first at random, and hold it until it is taken.
  task automatic send(input logic [MODE_W-1:0]  m,
                      input logic [INDEX_W-1:0] idx,
                      input logic [BYTE_W-1:0]  b);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    pattern_index <= idx;
    symbol        <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (m != MODE_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic load_pattern(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] b);
    pattern_bytes[idx] = b;
    send(MODE_PATTERN, idx, b);
  endtask

  // A text transfer; in the random part a pattern write may cut in first.
  task automatic send_text(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < stray_pct) begin
      load_pattern(INDEX_W'($urandom_range(0, PATTERN_LEN - 1)), text_byte());
    end
    send(MODE_TEXT, INDEX_W'($urandom_range(0, 15)), b);
  endtask

  task automatic end_text();
    send(MODE_EOT, INDEX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
    texts_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Result side: random stall bursts, or one long hold when asked.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req  <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        n = pick_gap();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int len;
    int lead;
    int tail;
    int random_start;
    logic [BYTE_W-1:0] b;

    in_valid      <= 1'b0;
    mode          <= MODE_PATTERN;
    pattern_index <= '0;
    symbol        <= '0;
    rst_n         <= 1'b0;
    for (int i = 0; i < PATTERN_LEN; i++) begin
      pattern_bytes[i] = QMARK;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part: run without idling or stalls ----
    // empty text: only the count transfer, zero
    end_text();
    // pattern: 'a' first, last position a plain symbol then a wildcard by
    // code rather than by '?', and a '?' written over a wildcard
    load_pattern(4'd15, 8'h00);
    load_pattern(4'd15, 8'hff);
    load_pattern(4'd0, "a");
    load_pattern(4'd7, QMARK);
    // short text: matches only through the trailing padding, at 0 and 3;
    // 0xff in the text codes as the wildcard and must not match 'a'
    send_text("a");
    send_text(8'h00);
    send_text(8'hff);
    send_text("a");
    // the unused mode in the middle of a text changes nothing
    send(MODE_UNUSED, 4'd15, 8'hff);
    end_text();
    send(MODE_UNUSED, 4'd0, 8'h00);
    end_text();
    wait_for_results();

    // ---- random part: texts that mostly carry the pattern ----
    random_start = items_sent;
    stray_pct    = 4;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 2);
      idle_pct  = (r == 0) ? 0 : (r == 1) ? 20 : 60;
      r = $urandom_range(0, 2);
      stall_pct = (r == 0) ? 0 : (r == 1) ? 25 : 60;

      // rewrite a few pattern positions, wildcards favoured
      if ($urandom_range(0, 99) < 40) begin
        repeat ($urandom_range(1, 4)) begin
          r = $urandom_range(0, 99);
          b = (r < 55) ? QMARK : (r < 90) ? text_byte() : BYTE_W'($urandom_range(0, 255));
          load_pattern(INDEX_W'($urandom_range(0, PATTERN_LEN - 1)), b);
        end
      end
      if ($urandom_range(0, 99) < 8) begin
        send(MODE_UNUSED, INDEX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
      end

      if ($urandom_range(0, 99) < 65) begin
        // embed the pattern, wildcard positions filled with random text
        lead = $urandom_range(0, 4);
        tail = $urandom_range(0, 4);
        repeat (lead) send_text(text_byte());
        for (int i = 0; i < PATTERN_LEN; i++) begin
          b = pattern_bytes[i];
          send_text((b[SYM_W-1:0] == WILDCARD) ? text_byte() : b);
        end
        repeat (tail) send_text(text_byte());
      end else begin
        // short or broken text, always ending before a full window
        len = $urandom_range(0, 10);
        repeat (len) send_text(text_byte());
      end
      end_text();

      if ($urandom_range(0, 7) == 0) begin
        wait_for_results();
      end
    end
    stray_pct = 0;

    // ---- pressure: every position matches, result side held off ----
    wait_for_results();
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < PATTERN_LEN; i++) begin
      load_pattern(INDEX_W'(i), QMARK);
    end
    // hold the result side off while text keeps arriving, so the block fills
    hold_req <= 1'b1;
    for (int i = 0; i < HOLD_TEXTS; i++) begin
      send_text(BYTE_W'($urandom_range(0, 255)));
    end
    end_text();
    // the next text must start clean: fresh count
    send_text("b");
    send_text("c");
    end_text();

    // ---- drain and verdict ----
    stall_pct = 0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transfers in %0d texts, with random gaps, stall bursts",
             items_sent, texts_sent);
    $display("and one long result hold; %0d predicted, %0d checked, %0d failures, %0d left.",
             predicted, checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
